@@ hdl/upc_pkg.sv @@
package upc_pkg;

	// payload widths
	localparam int CODE_W = 16;
	localparam int BYTE_W = 8;
	localparam int MAX_RES = 9;
	localparam int CNT_W = 4;

	// apb register map
	localparam int ADDR_W = 3;
	localparam logic REG_DECODE_MODE = 1'b0;

	// characters the codec treats specially
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	// escape tracking in decode mode
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_HIGH = 3'b010,
		PH_LOW  = 3'b100
	} phase_t;

	// all results of one item, handed from the expander to the serializer
	typedef struct packed {
		logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
		logic [CNT_W-1:0]               count;
		logic                           bare;
		logic                           final_unit;
		logic                           err;
	} bundle_t;

	function automatic logic is_unreserved(input logic [7:0] b);
		return (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) ||
			b == 8'h2D || b == 8'h5F || b == 8'h2E || b == CH_TILDE;
	endfunction

	// 0..15 for a hex digit, bit 4 set otherwise
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [7:0] d;
		d = 8'h00;
		if (b inside {[8'h30:8'h39]}) begin
			d = b - 8'h30;
		end else if (b inside {[8'h41:8'h46]}) begin
			d = b - 8'h37;
		end else if (b inside {[8'h61:8'h66]}) begin
			d = b - 8'h57;
		end else begin
			d = 8'h10;
		end
		return d[4:0];
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
	endfunction

endpackage

@@ hdl/upc_if.sv @@
interface upc_in_if import upc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] code_unit;
	logic              final_unit;

	modport source (output valid, output code_unit, output final_unit, input ready);
	modport sink (input valid, input code_unit, input final_unit, output ready);
endinterface

interface upc_out_if import upc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              byte_present;
	logic              run_last;
	logic              string_end;
	logic              malformed;

	modport source (output valid, output out_byte, output byte_present, output run_last,
		output string_end, output malformed, input ready);
	modport sink (input valid, input out_byte, input byte_present, input run_last,
		input string_end, input malformed, output ready);
endinterface

@@ hdl/upc_apb_regs.sv @@
module upc_apb_regs import upc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic              decode_mode
);

	logic decode_mode_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	// register write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
		end else if (wr_en && paddr[2] == REG_DECODE_MODE) begin
			decode_mode_q <= pwdata[0];
		end
	end

	// read back
	always_comb begin
		prdata = 32'h0;
		if (paddr[2] == REG_DECODE_MODE) begin
			prdata = {31'h0, decode_mode_q};
		end
	end

	assign decode_mode = decode_mode_q;

endmodule

@@ hdl/upc_expand.sv @@
module upc_expand import upc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       decode_mode,
	upc_in_if.sink     in_ch,
	input  logic       take_ok,
	output logic       push,
	output bundle_t    bnd
);

	logic [CODE_W-1:0] code_unit_s1;
	logic              final_s1;
	logic              valid_s1;

	phase_t            phase_q, phase_d;
	logic [3:0]        nibble_q, nibble_d;
	logic              err_q, err_d;

	logic [2:0][7:0]   utf;
	logic [1:0]        nbytes;
	logic              advance;

	// utf-8 expansion of one code unit, surrogates taken as they come
	always_comb begin
		utf = '0;
		if (code_unit_s1 < 16'h0080) begin
			utf[0] = code_unit_s1[7:0];
			nbytes = 2'd1;
		end else if (code_unit_s1 < 16'h0800) begin
			utf[0] = 8'hC0 | {3'b000, code_unit_s1[10:6]};
			utf[1] = 8'h80 | {2'b00, code_unit_s1[5:0]};
			nbytes = 2'd2;
		end else begin
			utf[0] = 8'hE0 | {4'h0, code_unit_s1[15:12]};
			utf[1] = 8'h80 | {2'b00, code_unit_s1[11:6]};
			utf[2] = 8'h80 | {2'b00, code_unit_s1[5:0]};
			nbytes = 2'd3;
		end
	end

	// encode or decode up to three bytes into the result bundle
	always_comb begin
		logic [CNT_W-1:0] cnt;
		logic [4:0]       hv;
		logic [7:0]       b;
		cnt = '0;
		hv = '0;
		b = '0;
		bnd = '0;
		phase_d = phase_q;
		nibble_d = nibble_q;
		err_d = err_q;
		for (int i = 0; i < 3; i++) begin
			b = utf[i];
			if (i < int'(nbytes)) begin
				if (!decode_mode) begin
					if (is_unreserved(b)) begin
						bnd.bytes[cnt] = b;
						cnt = cnt + 4'd1;
					end else begin
						bnd.bytes[cnt] = CH_PERCENT;
						bnd.bytes[cnt + 4'd1] = hex_digit(b[7:4]);
						bnd.bytes[cnt + 4'd2] = hex_digit(b[3:0]);
						cnt = cnt + 4'd3;
					end
				end else if (!err_d) begin
					hv = hex_value(b);
					case (phase_d)
						PH_IDLE: begin
							if (b == CH_PERCENT) begin
								phase_d = PH_HIGH;
							end else begin
								bnd.bytes[cnt] = (b == CH_PLUS) ? CH_SPACE : b;
								cnt = cnt + 4'd1;
							end
						end
						PH_HIGH: begin
							if (hv[4]) begin
								err_d = 1'b1;
							end else begin
								nibble_d = hv[3:0];
								phase_d = PH_LOW;
							end
						end
						default: begin
							if (hv[4]) begin
								err_d = 1'b1;
							end else begin
								bnd.bytes[cnt] = {nibble_d, hv[3:0]};
								cnt = cnt + 4'd1;
								phase_d = PH_IDLE;
								nibble_d = 4'h0;
							end
						end
					endcase
				end
			end
		end
		// string end: open escape is an error, then all state clears
		if (final_s1) begin
			if (decode_mode && phase_d != PH_IDLE) begin
				err_d = 1'b1;
			end
			if (cnt == '0) begin
				bnd.bare = 1'b1;
				cnt = 4'd1;
			end
		end
		bnd.count = cnt;
		bnd.final_unit = final_s1;
		bnd.err = err_d;
	end

	assign advance = valid_s1 && (bnd.count == '0 || take_ok);
	assign push = valid_s1 && bnd.count != '0 && take_ok;
	assign in_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			code_unit_s1 <= in_ch.code_unit;
			final_s1 <= in_ch.final_unit;
		end
	end

	// decode state moves on as each item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			nibble_q <= 4'h0;
			err_q <= 1'b0;
		end else if (advance) begin
			if (final_s1) begin
				phase_q <= PH_IDLE;
				nibble_q <= 4'h0;
				err_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				nibble_q <= nibble_d;
				err_q <= err_d;
			end
		end
	end

endmodule

@@ hdl/upc_serializer.sv @@
module upc_serializer import upc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  bundle_t    bnd,
	output logic       take_ok,
	upc_out_if.source  out_ch
);

	bundle_t          buf_s2;
	logic             valid_s2;
	logic [CNT_W-1:0] idx_q;
	logic             last;

	assign last = (idx_q == buf_s2.count - 4'd1);
	assign take_ok = !valid_s2 || (out_ch.ready && last);

	// one result beat per cycle from the held bundle, while out_ch is ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q <= '0;
		end else if (push) begin
			valid_s2 <= 1'b1;
			idx_q <= '0;
		end else if (valid_s2 && out_ch.ready) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_s2 <= bnd;
		end
	end

	// result fields
	assign out_ch.valid = valid_s2;
	assign out_ch.out_byte = buf_s2.bytes[idx_q];
	assign out_ch.byte_present = !buf_s2.bare;
	assign out_ch.run_last = last;
	assign out_ch.string_end = last && buf_s2.final_unit;
	assign out_ch.malformed = last && buf_s2.final_unit && buf_s2.err;

endmodule

@@ hdl/url_percent_codec.sv @@
// channel   dir  beat payload                                           handshake
// in_ch     in   code_unit[15:0], final_unit                            valid/ready
// out_ch    out  out_byte[7:0], byte_present, run_last, string_end,
//                malformed                                              valid/ready
// apb       in   decode_mode at byte address 0                          psel/penable/pready
//
// an item passes the input register and then the result register, and its results leave
// one beat per cycle while out_ch is ready; an item with n results (1 to 9) gives n beats,
// and the result register takes no new item until the last of them is taken
// a non-final item with no results leaves the input register without waiting and leaves no beat
// arst_n clears all handshake and decode state; encode mode after reset
// output stalls back up into the input register, which still takes one item meanwhile
module url_percent_codec import upc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	upc_in_if.sink            in_ch,
	upc_out_if.source         out_ch
);

	logic    decode_mode;
	logic    take_ok;
	logic    push;
	bundle_t bnd;

	// configuration register
	upc_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.decode_mode (decode_mode)
	);

	// input register and byte conversion
	upc_expand u_expand (
		.clk         (clk),
		.arst_n      (arst_n),
		.decode_mode (decode_mode),
		.in_ch       (in_ch),
		.take_ok     (take_ok),
		.push        (push),
		.bnd         (bnd)
	);

	// result register and beat sequencing
	upc_serializer u_ser (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.bnd     (bnd),
		.take_ok (take_ok),
		.out_ch  (out_ch)
	);

	// malformed only flags the end of a string
	a_malformed_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.malformed |-> out_ch.string_end)
		else $error("malformed without string_end");

	// string end closes the item's run
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.string_end |-> out_ch.run_last)
		else $error("string_end without run_last");

	// a bare marker only ever closes a string
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.byte_present |-> out_ch.string_end && out_ch.out_byte == 8'h00)
		else $error("bare marker in mid string");

	// encoded output is plain ascii
	a_encode_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !decode_mode && out_ch.byte_present |-> !out_ch.out_byte[7])
		else $error("non-ascii byte while encoding");

endmodule

@@ tb/sv/tb_url_percent_codec.sv @@
`timescale 1ns / 100ps

module tb_url_percent_codec import upc_pkg::*; ();

	localparam int RANDOM_UNITS = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [ADDR_W-1:0] MODE_ADDR = ADDR_W'(4 * int'(REG_DECODE_MODE));

	// one output beat as the block presents it
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       run_last;
		logic       string_end;
		logic       malformed;
	} beat_t;

	// one queued code unit of the generated text
	typedef struct packed {
		logic [15:0] cu;
		logic        fin;
	} text_unit_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC, RX_LONG} rx_style_t;

	// tracks the codec state and holds the beats still owed by the block
	class codec_scoreboard;
		bit         decode_mode = 1'b0;
		phase_t     phase = PH_IDLE;
		logic [3:0] hi_nib = 4'h0;
		bit         err = 1'b0;
		beat_t      awaited[$];
		beat_t      run[$];
		int         n_fail = 0;
		int         n_units = 0;
		int         n_strings = 0;
		int         n_bad_strings = 0;
		int         n_beats = 0;

		function automatic bit plain(input logic [7:0] c);
			return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
				(c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h5F ||
				c == 8'h2E || c == CH_TILDE;
		endfunction

		// bit 4 set when the character is no hex digit
		function automatic logic [4:0] nibble_of(input logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
			if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
			if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
			return 5'h10;
		endfunction

		function automatic logic [7:0] ascii_hex(input logic [3:0] v);
			return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v) - 8'd10;
		endfunction

		function automatic void emit(input logic [7:0] d);
			run.insert(run.size(), beat_t'{data: d, present: 1'b1, run_last: 1'b0,
				string_end: 1'b0, malformed: 1'b0});
		endfunction

		function automatic void encode_step(input logic [7:0] c);
			if (plain(c)) begin
				emit(c);
			end else begin
				emit(CH_PERCENT);
				emit(ascii_hex(c[7:4]));
				emit(ascii_hex(c[3:0]));
			end
		endfunction

		// escape state survives encode stretches untouched
		function automatic void decode_step(input logic [7:0] c);
			logic [4:0] v;
			if (err) return;
			v = nibble_of(c);
			case (phase)
				PH_IDLE: begin
					if (c == CH_PERCENT) phase = PH_HIGH;
					else if (c == CH_PLUS) emit(CH_SPACE);
					else emit(c);
				end
				PH_HIGH: begin
					if (v[4]) begin
						err = 1'b1;
					end else begin
						hi_nib = v[3:0];
						phase = PH_LOW;
					end
				end
				default: begin
					if (v[4]) begin
						err = 1'b1;
					end else begin
						emit({hi_nib, v[3:0]});
						phase = PH_IDLE;
						hi_nib = 4'h0;
					end
				end
			endcase
		endfunction

		// accepted unit: utf-8 expansion, then encode or decode per byte
		function automatic void note_unit(input logic [15:0] cu, input logic fin);
			logic [7:0] utf [3];
			int         n;
			run.delete();
			n_units++;
			if (cu < 16'h0080) begin
				utf[0] = cu[7:0];
				n = 1;
			end else if (cu < 16'h0800) begin
				utf[0] = {3'b110, cu[10:6]};
				utf[1] = {2'b10, cu[5:0]};
				n = 2;
			end else begin
				utf[0] = {4'b1110, cu[15:12]};
				utf[1] = {2'b10, cu[11:6]};
				utf[2] = {2'b10, cu[5:0]};
				n = 3;
			end
			for (int i = 0; i < n; i++) begin
				if (decode_mode) decode_step(utf[i]);
				else encode_step(utf[i]);
			end
			if (fin) begin
				if (decode_mode && phase != PH_IDLE) err = 1'b1;
				if (run.size() == 0) begin
					run.insert(run.size(), beat_t'{data: 8'h00, present: 1'b0,
						run_last: 1'b0, string_end: 1'b0, malformed: 1'b0});
				end
				run[$].string_end = 1'b1;
				run[$].malformed = err;
				n_strings++;
				if (err) n_bad_strings++;
				phase = PH_IDLE;
				hi_nib = 4'h0;
				err = 1'b0;
			end
			if (run.size() > 0) run[$].run_last = 1'b1;
			foreach (run[i]) awaited.insert(awaited.size(), run[i]);
		endfunction

		function automatic void report(input string name, input logic [7:0] want,
			input logic [7:0] got);
			n_fail++;
			$display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
		endfunction

		function automatic void check_beat(input beat_t got);
			beat_t want;
			n_beats++;
			if (awaited.size() == 0) begin
				n_fail++;
				$display("%0t: beat with nothing expected, expected none, got %h", $time, got);
				return;
			end
			want = awaited.pop_front();
			if (got.data !== want.data) report("out_byte", want.data, got.data);
			if (got.present !== want.present) report("byte_present", want.present, got.present);
			if (got.run_last !== want.run_last) report("run_last", want.run_last, got.run_last);
			if (got.string_end !== want.string_end)
				report("string_end", want.string_end, got.string_end);
			if (got.malformed !== want.malformed)
				report("malformed", want.malformed, got.malformed);
		endfunction

		function automatic int pending();
			return awaited.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	upc_in_if  in_ch();
	upc_out_if out_ch();

	codec_scoreboard sb = new();
	text_unit_t      text_q[$];
	int              burst_left = 0;
	int              cycle_cnt = 0;
	int              n_mode_writes = 0;
	rx_style_t       rx_style = RX_OPEN;
	int              rx_cnt = 0;

	url_percent_codec i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt, sb.pending());
			$display("tb_url_percent_codec: FAIL");
			$finish;
		end
	end

	// accepted input beats feed the predictor
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) sb.note_unit(in_ch.code_unit, in_ch.final_unit);
	end

	// accepted output beats are checked in order
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sb.check_beat(beat_t'{data: out_ch.out_byte, present: out_ch.byte_present,
				run_last: out_ch.run_last, string_end: out_ch.string_end,
				malformed: out_ch.malformed});
		end
	end

	// receiver backpressure, switching style whenever rx_cnt runs out
	always @(negedge clk) begin
		if (rx_cnt == 0) begin
			rx_style <= rx_style_t'($urandom_range(0, 4));
			rx_cnt <= $urandom_range(20, 80);
		end else begin
			rx_cnt <= rx_cnt - 1;
		end
		case (rx_style)
			RX_OPEN:     out_ch.ready <= 1'b1;
			RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 7) != 0);
			RX_PERIODIC: out_ch.ready <= (rx_cnt[1:0] != 2'b00);
			default:     out_ch.ready <= ((rx_cnt % 12) < 3);
		endcase
	end

	task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [31:0] d);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(input logic [ADDR_W-1:0] a, output logic [31:0] d);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		d = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_mode();
		logic [31:0] rd;
		apb_read(MODE_ADDR, rd);
		if (rd !== {31'b0, sb.decode_mode}) begin
			sb.n_fail++;
			$display("%0t: decode_mode readback mismatch, expected %0h, got %0h",
				$time, sb.decode_mode, rd);
		end
	endtask

	// stop sending and let everything owed drain out
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_mode(input bit m);
		settle();
		apb_write(MODE_ADDR, {31'b0, m});
		sb.decode_mode = m;
		n_mode_writes++;
		check_mode();
	endtask

	// sender: bursts of beats with random gaps in between
	task automatic send_unit(input logic [15:0] cu, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.code_unit <= cu;
		in_ch.final_unit <= fin;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	function automatic void push_text(input logic [15:0] cu);
		text_q.insert(text_q.size(), text_unit_t'{cu: cu, fin: 1'b0});
	endfunction

	function automatic logic [15:0] hex_unit(input logic [3:0] v);
		if (v < 4'd10) return 16'h30 + 16'(v);
		return (($urandom_range(0, 1) != 0) ? 16'h61 : 16'h41) + 16'(v) - 16'd10;
	endfunction

	// one string of random content; in decode mode mostly well-formed escapes
	task automatic fill_text(input bit dec);
		int          r;
		logic [15:0] cu;
		repeat ($urandom_range(1, 10)) begin
			r = $urandom_range(0, 99);
			if (!dec) begin
				if (r < 35) cu = 16'($urandom_range(0, 16'h7F));
				else if (r < 55) cu = 16'($urandom_range(16'h61, 16'h7A));
				else if (r < 75) cu = 16'($urandom_range(16'h80, 16'h7FF));
				else if (r < 92) cu = 16'($urandom_range(16'h800, 16'hFFFF));
				else cu = 16'($urandom_range(0, 16'hFFFF));
				push_text(cu);
			end else if (r < 45) begin
				cu = 16'($urandom_range(0, 16'h7F));
				if (cu[7:0] == CH_PERCENT) cu = 16'h2E;
				push_text(cu);
			end else if (r < 60) begin
				push_text({8'h00, CH_PLUS});
			end else if (r < 85) begin
				push_text({8'h00, CH_PERCENT});
				push_text(hex_unit(4'($urandom_range(0, 15))));
				push_text(hex_unit(4'($urandom_range(0, 15))));
			end else if (r < 93) begin
				push_text(16'($urandom_range(16'h80, 16'hFFFF)));
			end else if (r < 97) begin
				// escape broken by a non-hex character
				push_text({8'h00, CH_PERCENT});
				if ($urandom_range(0, 1) != 0) push_text(16'($urandom_range(16'h67, 16'h7A)));
				else push_text(16'($urandom_range(16'h80, 16'hFFFF)));
			end else begin
				push_text({8'h00, CH_PERCENT});
			end
		end
		text_q[$].fin = 1'b1;
	endtask

	initial begin
		bit         mode;
		int         sent;
		int         span;
		text_unit_t tu;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.code_unit = '0;
		in_ch.final_unit = 1'b0;
		out_ch.ready = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		check_mode();

		// encode: unreserved, escaped ascii, every utf-8 width, field extremes
		send_unit(16'h0041, 1'b0);
		send_unit(16'h007E, 1'b0);
		send_unit(16'h0020, 1'b0);
		send_unit(16'h0000, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hD800, 1'b0);  // lone surrogate
		send_unit(16'hFFFF, 1'b1);

		// decode: escapes in both cases, plus, multi-byte pass-through
		set_mode(1'b1);
		send_unit(16'h0025, 1'b0);
		send_unit(16'h0034, 1'b0);
		send_unit(16'h0031, 1'b0);
		send_unit({8'h00, CH_PLUS}, 1'b0);
		send_unit(16'h0025, 1'b0);
		send_unit(16'h0066, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'h00E9, 1'b0);
		// bad hex digit, rest suppressed, bare end marker flagged
		send_unit(16'h0025, 1'b0);
		send_unit(16'h0047, 1'b0);
		send_unit(16'h007A, 1'b1);
		// string ends inside an escape
		send_unit(16'h0025, 1'b0);
		send_unit(16'h0034, 1'b1);

		// escape split by an encode stretch, then resumed
		send_unit(16'h0025, 1'b0);
		send_unit(16'h0034, 1'b0);
		set_mode(1'b0);
		send_unit(16'h005A, 1'b0);
		set_mode(1'b1);
		send_unit(16'h0031, 1'b1);

		// error found while decoding still reported after switching to encode
		send_unit(16'h0025, 1'b0);
		send_unit(16'h0047, 1'b0);
		set_mode(1'b0);
		send_unit(16'h0061, 1'b1);

		// random phases, mode may change in the middle of a string
		mode = 1'b0;
		sent = 0;
		while (sent < RANDOM_UNITS) begin
			if ($urandom_range(0, 3) != 0) mode = ~mode;
			set_mode(mode);
			span = $urandom_range(8, 40);
			repeat (span) begin
				if (text_q.size() == 0) fill_text(mode);
				tu = text_q.pop_front();
				send_unit(tu.cu, tu.fin);
				sent++;
			end
		end
		while (text_q.size() != 0) begin
			tu = text_q.pop_front();
			send_unit(tu.cu, tu.fin);
		end
		settle();

		$display("covered %0d code units in %0d strings (%0d malformed), %0d output beats",
			sb.n_units, sb.n_strings, sb.n_bad_strings, sb.n_beats);
		$display("decode_mode written %0d times, including switches inside strings",
			n_mode_writes);
		if (sb.n_fail == 0 && sb.pending() == 0) begin
			$display("tb_url_percent_codec: PASS");
		end else begin
			$display("%0d mismatches, %0d beats never arrived", sb.n_fail, sb.pending());
			$display("tb_url_percent_codec: FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/upc_pkg.sv
hdl/upc_if.sv
hdl/upc_apb_regs.sv
hdl/upc_expand.sv
hdl/upc_serializer.sv
hdl/url_percent_codec.sv
tb/sv/tb_url_percent_codec.sv
